[sv/euclid_gcd_unit_core_assert.svh]
// Assertion macros shared by the gcd core.
`ifndef EUCLID_GCD_UNIT_CORE_ASSERT_SVH
`define EUCLID_GCD_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EGCD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define EGCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/egcd_pkg.sv]
// Package: widths, sequencer states and control structs of the gcd core.
`default_nettype none
package egcd_pkg;
   localparam int OPERAND_BITS = 31;
   localparam int CNT_BITS     = $clog2(OPERAND_BITS + 1);

   typedef logic [OPERAND_BITS-1:0] operand_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic        start;
      operand_type dividend;
      operand_type divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      operand_type remainder;
   } div_stat_type;
endpackage
`default_nettype wire

[sv/egcd_if.sv]
// Valid/ready channel interfaces for operand and result items.
`default_nettype none
interface egcd_req_if;
   logic                  valid;
   logic                  ready;
   egcd_pkg::operand_type first_value;
   egcd_pkg::operand_type second_value;

   modport source (output valid, output first_value, output second_value, input ready);
   modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface egcd_rsp_if;
   logic                  valid;
   logic                  ready;
   egcd_pkg::operand_type divisor_result;

   modport source (output valid, output divisor_result, input ready);
   modport sink   (input valid, input divisor_result, output ready);
endinterface
`default_nettype wire

[sv/egcd_divider.sv]
// Restoring remainder unit: one quotient bit per cycle.
`default_nettype none
module egcd_divider (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire egcd_pkg::div_req_type  div_req,
   output egcd_pkg::div_stat_type      div_stat
);
   localparam int N = egcd_pkg::OPERAND_BITS;
   localparam int C = egcd_pkg::CNT_BITS;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [C-1:0]  cnt_ff, cnt_in;
   logic [N-1:0]  rem_ff, rem_in;
   logic [N-1:0]  dvd_ff, dvd_in;
   logic [N-1:0]  dsr_ff, dsr_in;
   logic [N:0]    shifted;
   logic [N:0]    trial;

   always_comb begin
      shifted = {rem_ff, dvd_ff[N-1]};
      trial   = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = C'(N);
         rem_in  = '0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         // borrow out means the trial subtraction failed: keep the shifted value
         rem_in = trial[N] ? shifted[N-1:0] : trial[N-1:0];
         dvd_in = {dvd_ff[N-2:0], 1'b0};
         cnt_in = cnt_ff - C'(1);
         if (cnt_ff == C'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_stat.busy      = busy_ff;
   assign div_stat.done      = done_ff;
   assign div_stat.remainder = rem_ff;
endmodule
`default_nettype wire

[sv/egcd_ctrl.sv]
// Euclid sequencer: holds the operand pair, drives the remainder unit, registers results.
`default_nettype none
module egcd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   egcd_req_if.sink                    req_ch,
   egcd_rsp_if.source                  rsp_ch,
   output egcd_pkg::div_req_type       div_req,
   input  wire egcd_pkg::div_stat_type div_stat
);
   egcd_pkg::state_type   state_ff, state_in;
   egcd_pkg::operand_type x_ff, x_in;
   egcd_pkg::operand_type y_ff, y_in;
   egcd_pkg::operand_type res_ff, res_in;
   logic                  sel_x_ff, sel_x_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic x_zero, y_zero, any_zero, x_gt, out_free;
   logic accept, start, load_rsp;

   assign x_zero   = (x_ff == '0);
   assign y_zero   = (y_ff == '0);
   assign any_zero = x_zero || y_zero;
   assign x_gt     = (x_ff > y_ff);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         egcd_pkg::ST_IDLE:  if (req_ch.valid) state_in = egcd_pkg::ST_CHECK;
         egcd_pkg::ST_CHECK: begin
            if (!any_zero)     state_in = egcd_pkg::ST_DIV;
            else if (out_free) state_in = egcd_pkg::ST_IDLE;
         end
         egcd_pkg::ST_DIV:   if (div_stat.done) state_in = egcd_pkg::ST_CHECK;
         default:            state_in = egcd_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ch.ready = 1'b0;
      start        = 1'b0;
      load_rsp     = 1'b0;
      unique case (state_ff)
         egcd_pkg::ST_IDLE:  req_ch.ready = 1'b1;
         egcd_pkg::ST_CHECK: begin
            start    = !any_zero;
            load_rsp = any_zero && out_free;
         end
         egcd_pkg::ST_DIV:   ;
         default:            ;
      endcase
   end

   assign accept = req_ch.valid && req_ch.ready;

   assign div_req.start    = start;
   assign div_req.dividend = x_gt ? x_ff : y_ff;
   assign div_req.divisor  = x_gt ? y_ff : x_ff;

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      sel_x_in = sel_x_ff;
      res_in   = res_ff;
      if (accept) begin
         x_in = req_ch.first_value;
         y_in = req_ch.second_value;
      end
      if (start) sel_x_in = x_gt;
      // the larger operand takes the remainder; on a tie the second one does
      if ((state_ff == egcd_pkg::ST_DIV) && div_stat.done) begin
         if (sel_x_ff) x_in = div_stat.remainder;
         else          y_in = div_stat.remainder;
      end
      if (load_rsp) res_in = x_zero ? y_ff : x_ff;
      if (load_rsp)          rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= egcd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      sel_x_ff <= sel_x_in;
      res_ff   <= res_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.divisor_result = res_ff;
endmodule
`default_nettype wire

[sv/euclid_gcd_unit_core.sv]
// Euclid gcd core: one item at a time, each remainder step run on the bit-serial divider.
// The time from accept to result grows with the number of remainder steps.
// The next item can be accepted in the cycle after the result is registered.
// Reset: synchronous, active high; clears the sequencer, divider and result valid.
`default_nettype none
`include "euclid_gcd_unit_core_assert.svh"
module euclid_gcd_unit_core (
   input  wire logic  clock,
   input  wire logic  reset,
   egcd_req_if.sink   req_ch,
   egcd_rsp_if.source rsp_ch
);
   egcd_pkg::div_req_type  div_req;
   egcd_pkg::div_stat_type div_stat;

   egcd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .div_req  (div_req),
      .div_stat (div_stat)
   );

   egcd_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_stat (div_stat)
   );

   `EGCD_ASSERT_NOW(a_start_idle, div_req.start, !div_stat.busy, "divider restarted while busy")
   `EGCD_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready, "item taken while busy")
   `EGCD_ASSERT_NEXT(a_no_accept_in_div, div_stat.busy, !(req_ch.valid && req_ch.ready), "item taken during division")
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the Euclid gcd core: directed and random operand items.
`default_nettype none
module tb_top;
   localparam egcd_pkg::operand_type OPERAND_MAX     = {egcd_pkg::OPERAND_BITS{1'b1}};
   localparam int                    WATCHDOG_CYCLES = 8000;
   localparam int                    DRAIN_CYCLES    = 1700;   // worst-case item latency plus margin
   localparam int                    RANDOM_ITEMS    = 400;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;
   typedef enum int {
      MIX_FULL, MIX_FACTOR, MIX_TINY, MIX_ZERO, MIX_EQUAL, MIX_FIB
   } operand_mix_type;

   class gcd_scoreboard_type;
      egcd_pkg::operand_type expected_gcd[$];
      int                    error_count;

      function new();
         error_count = 0;
      endfunction

      function egcd_pkg::operand_type euclid_gcd(egcd_pkg::operand_type a,
                                                 egcd_pkg::operand_type b);
         egcd_pkg::operand_type x;
         egcd_pkg::operand_type y;
         x = a;
         y = b;
         while (x != 0 && y != 0) begin
            if (x > y) x = x % y;
            else       y = y % x;
         end
         return (x == 0) ? y : x;
      endfunction

      function void note_operands(egcd_pkg::operand_type a, egcd_pkg::operand_type b);
         expected_gcd = {expected_gcd, euclid_gcd(a, b)};
      endfunction

      function void check_result(egcd_pkg::operand_type got);
         egcd_pkg::operand_type want;
         if (expected_gcd.size() == 0) begin
            $error("divisor_result: no item expected, got %0d", got);
            error_count++;
         end else begin
            want = expected_gcd.pop_front();
            if (got !== want) begin
               $error("divisor_result: expected %0d, got %0d", want, got);
               error_count++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_count;

   egcd_req_if req_if();
   egcd_rsp_if rsp_if();

   gcd_scoreboard_type sb = new();

   euclid_gcd_unit_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // monitors and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_operands(req_if.first_value, req_if.second_value);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.divisor_result);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_count <= 0;
         end else if (idle_count + 1 >= WATCHDOG_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
         end else begin
            idle_count <= idle_count + 1;
         end
      end
   end

   function automatic egcd_pkg::operand_type rand_operand();
      int w;
      w = $urandom_range(1, egcd_pkg::OPERAND_BITS);
      return egcd_pkg::operand_type'($urandom()) >> (egcd_pkg::OPERAND_BITS - w);
   endfunction

   task automatic send_item(egcd_pkg::operand_type a, egcd_pkg::operand_type b);
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.first_value  <= a;
      req_if.second_value <= b;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   // pause: valid low, with junk on the data lines
   task automatic pause_sender(int n);
      for (int i = 0; i < n; i++) begin
         @(negedge clock);
         req_if.valid        <= 1'b0;
         req_if.first_value  <= egcd_pkg::operand_type'($urandom());
         req_if.second_value <= egcd_pkg::operand_type'($urandom());
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.expected_gcd.size() != 0) @(negedge clock);
   endtask

   // receiver: switches between stall patterns, holding each for a random span
   initial begin
      rx_mode_type mode;
      int          span;
      int          period;
      rsp_if.ready = 1'b0;
      forever begin
         mode   = rx_mode_type'($urandom_range(0, 3));
         span   = $urandom_range(40, 400);
         period = $urandom_range(2, 6);
         for (int i = 0; i < span; i++) begin
            @(negedge clock);
            case (mode)
               RX_OPEN:     rsp_if.ready <= 1'b1;
               RX_COIN:     rsp_if.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE:   rsp_if.ready <= ($urandom_range(0, 7) == 0);
               default:     rsp_if.ready <= (i % period == 0);
            endcase
         end
      end
   end

   initial begin
      egcd_pkg::operand_type dir_first [22] = '{
         31'd0, 31'd0, OPERAND_MAX, OPERAND_MAX, 31'd1, OPERAND_MAX,
         31'd1836311903, 31'd1134903170,
         31'd12345, OPERAND_MAX, 31'h4000_0000, 31'h2AAA_AAAA, 31'd12, 31'd7, 31'd0, 31'd1,
         OPERAND_MAX - 31'd1, 31'd6000, 31'h0000_0001, 31'd97, 31'd1024, 31'h7FFF_FFFE
      };
      egcd_pkg::operand_type dir_second[22] = '{
         31'd0, OPERAND_MAX, 31'd0, OPERAND_MAX, OPERAND_MAX, 31'd1,
         31'd1134903170, 31'd1836311903,
         31'd12345, OPERAND_MAX - 31'd1, 31'h0010_0000, 31'h5555_5555, 31'd18, 31'd0,
         31'd1, 31'd1,
         OPERAND_MAX, 31'd4000, 31'h4000_0000, 31'd97000291, 31'd1, 31'h3FFF_FFFF
      };
      egcd_pkg::operand_type a;
      egcd_pkg::operand_type b;
      egcd_pkg::operand_type g;
      logic [31:0]           fa;
      logic [31:0]           fb;
      logic [31:0]           ft;
      operand_mix_type       mix;
      int                    burst_left;

      reset               = 1'b1;
      idle_count          = 0;
      req_if.valid        = 1'b0;
      req_if.first_value  = '0;
      req_if.second_value = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_first[i]) send_item(dir_first[i], dir_second[i]);
      drain_results();

      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain_results();
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            pause_sender($urandom_range(1, 30));
         end
         burst_left--;
         mix = operand_mix_type'($urandom_range(0, 9) % 6);
         case (mix)
            MIX_FULL: begin
               a = egcd_pkg::operand_type'($urandom());
               b = egcd_pkg::operand_type'($urandom());
            end
            MIX_FACTOR: begin
               g = rand_operand();
               a = g * egcd_pkg::operand_type'($urandom_range(1, 300));
               b = g * egcd_pkg::operand_type'($urandom_range(1, 300));
            end
            MIX_TINY: begin
               a = egcd_pkg::operand_type'($urandom_range(0, 255));
               b = egcd_pkg::operand_type'($urandom_range(0, 255));
            end
            MIX_ZERO: begin
               a = $urandom_range(0, 1) ? rand_operand() : '0;
               b = (a == 0) ? rand_operand() : '0;
            end
            MIX_EQUAL: begin
               a = rand_operand();
               b = $urandom_range(0, 1) ? a : a * egcd_pkg::operand_type'($urandom_range(2, 9));
            end
            default: begin
               // consecutive Fibonacci numbers: the longest remainder chains
               fa = 0;
               fb = 1;
               repeat ($urandom_range(2, 45)) begin
                  ft = fa + fb;
                  fa = fb;
                  fb = ft;
               end
               a = egcd_pkg::operand_type'(fb);
               b = egcd_pkg::operand_type'(fa);
               if ($urandom_range(0, 1)) begin
                  a = egcd_pkg::operand_type'(fa);
                  b = egcd_pkg::operand_type'(fb);
               end
            end
         endcase
         send_item(a, b);
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.expected_gcd.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.error_count == 0 && sb.expected_gcd.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
+incdir+sv
sv/egcd_pkg.sv
sv/egcd_if.sv
sv/egcd_divider.sv
sv/egcd_ctrl.sv
sv/euclid_gcd_unit_core.sv
tb/tb_top.sv
